// ===== rtl/core/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, constants and the US keyboard table for the scancode line
// editor.
// ----------------------------------------------------------------------------
package sle_pkg;

  // Line lengths are held on six bits, enough for any capacity up to 63.
  localparam int LEN_W             = 6;
  localparam int LINE_CAPACITY_DEF = 32;

  localparam logic [7:0] CODE_BACKSPACE = 8'h0E;
  localparam logic [7:0] CODE_ENTER     = 8'h1C;
  localparam logic [6:0] KEY_PRINT_MAX  = 7'd57;
  localparam logic [6:0] KEY_LCTRL      = 7'h1D;
  localparam logic [6:0] KEY_LSHIFT     = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT     = 7'h36;
  localparam logic [6:0] KEY_LALT       = 7'h38;
  localparam int         REL_BIT        = 7;

  localparam logic [6:0] CASE_OFFSET = 7'h20;
  localparam logic [6:0] ASCII_UC_A  = 7'h41;
  localparam logic [6:0] ASCII_UC_Z  = 7'h5A;

  localparam int MOD_SHIFT = 0;
  localparam int MOD_CTRL  = 1;
  localparam int MOD_ALT   = 3;

  // Result kinds.
  localparam logic [1:0] KIND_ECHO_CHAR = 2'd0;
  localparam logic [1:0] KIND_ECHO_BS   = 2'd1;
  localparam logic [1:0] KIND_LINE_CHAR = 2'd2;
  localparam logic [1:0] KIND_LINE_END  = 2'd3;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_BS   = 2'd1,
    ACT_CHAR = 2'd2
  } act_t;

  // One command from the front end to the back end.
  typedef struct packed {
    logic             drain;
    logic [LEN_W-1:0] dlen;
    act_t             act;
    logic [6:0]       ch;
    logic [LEN_W-1:0] waddr;
    logic [3:0]       mods;
  } cmd_t;

  // US layout for key codes 0 to 57; zero marks a key with no character.
  function automatic logic [6:0] us_char(input logic [5:0] key);
    logic [6:0] c;
    case (key)
      6'd2:  c = 7'h31;
      6'd3:  c = 7'h32;
      6'd4:  c = 7'h33;
      6'd5:  c = 7'h34;
      6'd6:  c = 7'h35;
      6'd7:  c = 7'h36;
      6'd8:  c = 7'h37;
      6'd9:  c = 7'h38;
      6'd10: c = 7'h39;
      6'd11: c = 7'h30;
      6'd12: c = 7'h2D;
      6'd13: c = 7'h3D;
      6'd16: c = 7'h51;
      6'd17: c = 7'h57;
      6'd18: c = 7'h45;
      6'd19: c = 7'h52;
      6'd20: c = 7'h54;
      6'd21: c = 7'h59;
      6'd22: c = 7'h55;
      6'd23: c = 7'h49;
      6'd24: c = 7'h4F;
      6'd25: c = 7'h50;
      6'd26: c = 7'h5B;
      6'd27: c = 7'h5D;
      6'd30: c = 7'h41;
      6'd31: c = 7'h53;
      6'd32: c = 7'h44;
      6'd33: c = 7'h46;
      6'd34: c = 7'h47;
      6'd35: c = 7'h48;
      6'd36: c = 7'h4A;
      6'd37: c = 7'h4B;
      6'd38: c = 7'h4C;
      6'd39: c = 7'h3B;
      6'd40: c = 7'h27;
      6'd41: c = 7'h60;
      6'd43: c = 7'h5C;
      6'd44: c = 7'h5A;
      6'd45: c = 7'h58;
      6'd46: c = 7'h43;
      6'd47: c = 7'h56;
      6'd48: c = 7'h42;
      6'd49: c = 7'h4E;
      6'd50: c = 7'h4D;
      6'd51: c = 7'h2C;
      6'd52: c = 7'h2E;
      6'd53: c = 7'h2F;
      6'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/sle_ram.sv =====
// ----------------------------------------------------------------------------
// sle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sle_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sle_front.sv =====
// ----------------------------------------------------------------------------
// sle_front
// Accepts scancodes, tracks line length and modifier flags, and turns each
// scancode into at most one command for the back end.
// ----------------------------------------------------------------------------
module sle_front #(
  parameter int LINE_CAPACITY = sle_pkg::LINE_CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  logic [7:0]    in_scan_byte,
  input  logic          cq_full,
  output logic          cmd_push,
  output sle_pkg::cmd_t cmd
);

  import sle_pkg::*;

  localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_CAPACITY);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [3:0]       mods_r, mods_nxt;
  logic             accept;
  logic [6:0]       key;
  logic [6:0]       ch;
  logic [LEN_W-1:0] base;

  assign accept = in_push && !cq_full;
  assign key    = in_scan_byte[6:0];

  always_comb begin
    len_nxt   = len_r;
    mods_nxt  = mods_r;
    cmd_push  = 1'b0;
    cmd.drain = 1'b0;
    cmd.dlen  = len_r;
    cmd.act   = ACT_NONE;
    cmd.ch    = 7'd0;
    cmd.waddr = len_r;
    ch        = us_char(key[5:0]);
    base      = len_r;
    if (accept) begin
      if (in_scan_byte == CODE_BACKSPACE) begin
        if (len_r != '0) begin
          len_nxt  = len_r - 1'b1;
          cmd.act  = ACT_BS;
          cmd_push = 1'b1;
        end
      end else if (in_scan_byte == CODE_ENTER) begin
        cmd.drain = 1'b1;
        len_nxt   = '0;
        cmd_push  = 1'b1;
      end else begin
        // A full line is flushed before the scancode itself is handled.
        if (len_r >= CAP) begin
          cmd.drain = 1'b1;
          base      = '0;
          len_nxt   = '0;
          cmd_push  = 1'b1;
        end
        if (key <= KEY_PRINT_MAX) begin
          if (ch == 7'd0) begin
            case (key)
              KEY_LCTRL:  mods_nxt[MOD_CTRL]  = ~in_scan_byte[REL_BIT];
              KEY_LSHIFT: mods_nxt[MOD_SHIFT] = ~in_scan_byte[REL_BIT];
              KEY_RSHIFT: mods_nxt[MOD_SHIFT] = ~in_scan_byte[REL_BIT];
              KEY_LALT:   mods_nxt[MOD_ALT]   = ~in_scan_byte[REL_BIT];
              default:    mods_nxt = mods_r;
            endcase
          end else if (!in_scan_byte[REL_BIT]) begin
            if (!mods_r[MOD_SHIFT] && (ch inside {[ASCII_UC_A:ASCII_UC_Z]})) begin
              ch = ch + CASE_OFFSET;
            end
            cmd.act   = ACT_CHAR;
            cmd.ch    = ch;
            cmd.waddr = base;
            len_nxt   = base + 1'b1;
            cmd_push  = 1'b1;
          end
        end
      end
    end
    cmd.mods = mods_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      mods_r <= 4'd0;
    end else begin
      len_r  <= len_nxt;
      mods_r <= mods_nxt;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CAP)
    else $error("line length beyond capacity");

endmodule

// ===== rtl/core/sle_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// sle_cmd_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sle_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sle_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output sle_pkg::cmd_t rdata
);

  import sle_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/core/sle_back.sv =====
// ----------------------------------------------------------------------------
// sle_back
// Carries out commands: drains the line store, echoes edits, and queues the
// results in a small output queue.
// ----------------------------------------------------------------------------
module sle_back #(
  parameter int LINE_CAPACITY = sle_pkg::LINE_CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  sle_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          out_pop,
  output logic          out_empty,
  output logic [1:0]    out_kind,
  output logic [6:0]    out_char_code,
  output logic          out_last,
  output logic [3:0]    out_modifiers
);

  import sle_pkg::*;

  localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam int OQ_DEPTH = 4;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DRAIN = 4'b0010,
    ST_END   = 4'b0100,
    ST_ACT   = 4'b1000
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] ch;
    logic       last;
    logic [3:0] mods;
  } res_t;

  state_t           state_r, state_nxt;
  cmd_t             cur_r, cur_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;

  // Slot stage: holds each result while its registered RAM read completes.
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_ram_r, s1_ram_nxt;
  res_t             s1_r, s1_nxt;

  res_t             oq_r [OQ_DEPTH];
  logic [1:0]       oq_wr_r, oq_rd_r;
  logic [2:0]       oq_cnt_r;
  logic             oq_pop;
  res_t             push_res;

  logic             slot_ok;
  logic             ram_we;
  logic [AW-1:0]    ram_raddr;
  logic [6:0]       ram_rdata;

  sle_ram #(
    .WIDTH (7),
    .DEPTH (LINE_CAPACITY)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_r.waddr[AW-1:0]),
    .wdata (cur_r.ch),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A slot is issued only when the output queue can take it, counting the
  // one still in the read stage.
  assign slot_ok   = ({1'b0, oq_cnt_r} + {3'd0, s1_valid_r}) < 4'(OQ_DEPTH);
  assign ram_raddr = idx_r[AW-1:0];

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    idx_nxt      = idx_r;
    cmd_pop      = 1'b0;
    ram_we       = 1'b0;
    s1_valid_nxt = 1'b0;
    s1_ram_nxt   = 1'b0;
    s1_nxt.kind  = KIND_LINE_CHAR;
    s1_nxt.ch    = 7'd0;
    s1_nxt.last  = 1'b0;
    s1_nxt.mods  = cur_r.mods;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cur_nxt = cmd;
          idx_nxt = '0;
          if (!cmd.drain) begin
            state_nxt = ST_ACT;
          end else if (cmd.dlen != '0) begin
            state_nxt = ST_DRAIN;
          end else begin
            state_nxt = ST_END;
          end
        end
      end
      ST_DRAIN: begin
        if (slot_ok) begin
          s1_valid_nxt = 1'b1;
          s1_ram_nxt   = 1'b1;
          s1_nxt.kind  = KIND_LINE_CHAR;
          if (idx_r == cur_r.dlen - 1'b1) begin
            state_nxt = ST_END;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_END: begin
        if (slot_ok) begin
          s1_valid_nxt = 1'b1;
          s1_nxt.kind  = KIND_LINE_END;
          s1_nxt.last  = (cur_r.act == ACT_NONE);
          state_nxt    = (cur_r.act == ACT_NONE) ? ST_IDLE : ST_ACT;
        end
      end
      ST_ACT: begin
        if (slot_ok) begin
          s1_valid_nxt = 1'b1;
          s1_nxt.last  = 1'b1;
          if (cur_r.act == ACT_CHAR) begin
            s1_nxt.kind = KIND_ECHO_CHAR;
            s1_nxt.ch   = cur_r.ch;
            ram_we      = 1'b1;
          end else begin
            s1_nxt.kind = KIND_ECHO_BS;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    push_res    = s1_r;
    push_res.ch = s1_ram_r ? ram_rdata : s1_r.ch;
  end

  assign out_empty     = (oq_cnt_r == 3'd0);
  assign oq_pop        = out_pop && !out_empty;
  assign out_kind      = oq_r[oq_rd_r].kind;
  assign out_char_code = oq_r[oq_rd_r].ch;
  assign out_last      = oq_r[oq_rd_r].last;
  assign out_modifiers = oq_r[oq_rd_r].mods;

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    idx_r    <= idx_nxt;
    s1_r     <= s1_nxt;
    s1_ram_r <= s1_ram_nxt;
    if (s1_valid_r) begin
      oq_r[oq_wr_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      s1_valid_r <= 1'b0;
      oq_wr_r    <= 2'd0;
      oq_rd_r    <= 2'd0;
      oq_cnt_r   <= 3'd0;
    end else begin
      state_r    <= state_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (s1_valid_r) begin
        oq_wr_r <= oq_wr_r + 2'd1;
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + 2'd1;
      end
      oq_cnt_r <= oq_cnt_r + {2'd0, s1_valid_r} - {2'd0, oq_pop};
    end
  end

  a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (oq_cnt_r < 3'(OQ_DEPTH)))
    else $error("result beat arrives at a full output queue");

  a_drain_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (cur_r.dlen != '0 && idx_r < cur_r.dlen))
    else $error("drain index outside the line");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == ST_IDLE && cmd_valid))
    else $error("command taken while busy");

endmodule

// ===== rtl/core/scancode_line_editor_top.sv =====
// ----------------------------------------------------------------------------
// scancode_line_editor_top
// Set-1 scancode line editor: modifier tracking, line buffer and line drain.
// ----------------------------------------------------------------------------
// Push raw set-1 scancodes; pop echo, backspace, line-character and line-end
// results, each carrying the modifier flags as they stand after its scancode.
// The front end takes a scancode whenever the two-entry command queue has
// room. The back-end sequencer loads a command while idle and then issues one
// result per cycle, while the output queue has room, through the line RAM's
// single read port. Results pass through a registered read stage into a
// four-entry output queue that drives the ports. The line RAM needs no
// clearing after reset.
// ----------------------------------------------------------------------------
module scancode_line_editor_top #(
  parameter int LINE_CAPACITY = sle_pkg::LINE_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_scan_byte,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_kind,
  output logic [6:0] out_char_code,
  output logic       out_last,
  output logic [3:0] out_modifiers
);

  import sle_pkg::*;

  cmd_t fe_cmd, be_cmd;
  logic fe_push, cq_full, cq_empty, be_pop;

  assign full = cq_full;

  sle_front #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (push),
    .in_scan_byte (in_scan_byte),
    .cq_full      (cq_full),
    .cmd_push     (fe_push),
    .cmd          (fe_cmd)
  );

  sle_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_push),
    .wdata (fe_cmd),
    .full  (cq_full),
    .pop   (be_pop),
    .empty (cq_empty),
    .rdata (be_cmd)
  );

  sle_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (!cq_empty),
    .cmd           (be_cmd),
    .cmd_pop       (be_pop),
    .out_pop       (pop),
    .out_empty     (empty),
    .out_kind      (out_kind),
    .out_char_code (out_char_code),
    .out_last      (out_last),
    .out_modifiers (out_modifiers)
  );

endmodule

// ===== verif/tb_scancode_line_editor_top.sv =====
// ----------------------------------------------------------------------------
// tb_scancode_line_editor_top
// Self-checking testbench for the set-1 scancode line editor.
// ----------------------------------------------------------------------------
// A short table of directed scancodes is followed by random typing: words with
// shift, backspace, enter, modifier changes, overlong lines and raw noise.
// Every accepted scancode is run through a line-editor predictor kept in this
// file, and each popped result is compared field by field with the oldest
// predicted one. The sender pushes in bursts and the receiver stalls on a
// pattern of its own, with one long hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_scancode_line_editor_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sle_pkg::*;

  localparam int LINE_CAP     = LINE_CAPACITY_DEF;
  localparam int RANDOM_BEATS = 450;
  localparam int HOLD_AT_BEAT = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] ch;
    logic       last;
    logic [3:0] mods;
  } line_result_t;

  typedef struct packed {
    logic [7:0] scan;
    bit         typed;
    bit         one_result;
    logic [1:0] kind;
    logic [6:0] ch;
    logic [3:0] mods;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_scan_byte = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [1:0] out_kind;
  logic [6:0] out_char_code;
  logic       out_last;
  logic [3:0] out_modifiers;

  // Predictor state.
  logic [6:0]   line_chars [LINE_CAP];
  int           line_len = 0;
  logic [3:0]   mod_flags = 4'h0;
  line_result_t step_results[$];
  line_result_t pending_results[$];

  logic [7:0] scan_plan[$];
  int         burst_left = 0;
  int         errors = 0;
  int         results_checked = 0;
  int         line_ends = 0;
  int         full_drains = 0;
  int         beats_seen = 0;
  int         full_stalls = 0;
  int         random_beats = 0;

  logic [15:0]  pop_mask = 16'hFFFF;
  int unsigned  rx_phase = 0;
  int           hold_left = 0;
  bit           hold_done = 1'b0;
  line_result_t rx_want;

  scancode_line_editor_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_scan_byte  (in_scan_byte),
    .empty         (empty),
    .pop           (pop),
    .out_kind      (out_kind),
    .out_char_code (out_char_code),
    .out_last      (out_last),
    .out_modifiers (out_modifiers)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // US layout by key code; '#' marks a key that types nothing.
  function automatic logic [6:0] key_char(input logic [6:0] key);
    string      layout;
    byte        b;
    logic [6:0] c;
    layout = "##1234567890-=##QWERTYUIOP[]##ASDFGHJKL;'`#\\ZXCVBNM,./### ";
    c = 7'h00;
    if (key <= KEY_PRINT_MAX) begin
      b = layout[key];
      if (b != "#") c = b[6:0];
    end
    return c;
  endfunction

  function automatic void add_result(input logic [1:0] kind, input logic [6:0] ch);
    line_result_t r;
    r.kind = kind;
    r.ch   = ch;
    r.last = 1'b0;
    r.mods = 4'h0;
    step_results.push_back(r);
  endfunction

  function automatic void flush_line();
    for (int i = 0; i < line_len; i++) add_result(KIND_LINE_CHAR, line_chars[i]);
    add_result(KIND_LINE_END, 7'h00);
    line_ends++;
    line_len = 0;
  endfunction

  // Updates the editor state for one scancode and, when keep is set, queues
  // the results it causes. Returns whether the scancode did anything at all.
  function automatic bit apply_scancode(input logic [7:0] code, input bit keep);
    logic [6:0] key;
    logic [6:0] ch;
    int         mod_idx;
    int         len_was;
    logic [3:0] mods_was;
    line_result_t r;
    key      = code[6:0];
    len_was  = line_len;
    mods_was = mod_flags;
    step_results.delete();
    if (code == CODE_BACKSPACE) begin
      if (line_len > 0) begin
        line_len--;
        add_result(KIND_ECHO_BS, 7'h00);
      end
    end else if (code == CODE_ENTER) begin
      flush_line();
    end else begin
      // A full line goes out first, whatever the scancode turns out to be.
      if (line_len >= LINE_CAP) begin
        full_drains++;
        flush_line();
      end
      if (key <= KEY_PRINT_MAX) begin
        ch = key_char(key);
        if (ch == 7'h00) begin
          case (key)
            KEY_LCTRL:              mod_idx = MOD_CTRL;
            KEY_LSHIFT, KEY_RSHIFT: mod_idx = MOD_SHIFT;
            KEY_LALT:               mod_idx = MOD_ALT;
            default:                mod_idx = -1;
          endcase
          if (mod_idx >= 0) mod_flags[mod_idx] = !code[REL_BIT];
        end else if (!code[REL_BIT]) begin
          if (!mod_flags[MOD_SHIFT] && ch >= ASCII_UC_A && ch <= ASCII_UC_Z)
            ch = ch + CASE_OFFSET;
          if (line_len < LINE_CAP) begin
            line_chars[line_len] = ch;
            line_len++;
          end
          add_result(KIND_ECHO_CHAR, ch);
        end
      end
    end
    foreach (step_results[k]) begin
      r = step_results[k];
      r.last = (k == step_results.size() - 1);
      r.mods = mod_flags;
      if (keep) pending_results.push_back(r);
    end
    return (step_results.size() > 0) || (line_len != len_was) || (mod_flags != mods_was);
  endfunction

  function automatic stim_row_t row(input logic [7:0] scan, input bit typed,
                                    input bit one_result, input logic [1:0] kind,
                                    input logic [6:0] ch, input logic [3:0] mods);
    stim_row_t s;
    s.scan       = scan;
    s.typed      = typed;
    s.one_result = one_result;
    s.kind       = kind;
    s.ch         = ch;
    s.mods       = mods;
    return s;
  endfunction

  // Offers one scancode and returns at the edge where it is accepted.
  task automatic offer_beat(input logic [7:0] scan);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    in_scan_byte <= scan;
    push         <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
  endtask

  task automatic plan_sequence();
    int         sel;
    int         len;
    bit         shifted;
    logic [6:0] key;
    logic [6:0] shift_key;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      // A word, now and then long enough to overrun the line.
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 10);
      shifted   = ($urandom_range(0, 3) == 0);
      shift_key = $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT;
      if (shifted) scan_plan.push_back({1'b0, shift_key});
      repeat (len) begin
        do key = 7'($urandom_range(0, KEY_PRINT_MAX)); while (key_char(key) == 7'h00);
        scan_plan.push_back({1'b0, key});
        if ($urandom_range(0, 3) == 0) scan_plan.push_back({1'b1, key});
        if ($urandom_range(0, 15) == 0) scan_plan.push_back(CODE_BACKSPACE);
      end
      if (shifted) scan_plan.push_back({1'b1, shift_key});
      case ($urandom_range(0, 3))
        0, 1:    scan_plan.push_back(CODE_ENTER);
        2:       scan_plan.push_back(8'($urandom_range(0, 255)));
        default: ;
      endcase
    end else if (sel < 65) begin
      repeat ($urandom_range(1, 6)) scan_plan.push_back(CODE_BACKSPACE);
    end else if (sel < 75) begin
      scan_plan.push_back(CODE_ENTER);
      if ($urandom_range(0, 1) == 0) scan_plan.push_back({1'b1, CODE_ENTER[6:0]});
    end else if (sel < 88) begin
      case ($urandom_range(0, 3))
        0:       key = KEY_LCTRL;
        1:       key = KEY_LSHIFT;
        2:       key = KEY_RSHIFT;
        default: key = KEY_LALT;
      endcase
      scan_plan.push_back({1'($urandom_range(0, 1)), key});
    end else begin
      repeat ($urandom_range(1, 3)) scan_plan.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Receiver: checks every popped beat and stalls on its own pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (push && !full) beats_seen++;
      if (push && full) full_stalls++;
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d char %h last %b mods %h",
                                    out_kind, out_char_code, out_last, out_modifiers));
        end else begin
          rx_want = pending_results.pop_front();
          results_checked++;
          if (out_kind !== rx_want.kind)
            report_mismatch($sformatf("result %0d: kind %0d, expected %0d",
                                      results_checked, out_kind, rx_want.kind));
          if (out_char_code !== rx_want.ch)
            report_mismatch($sformatf("result %0d: char %h, expected %h",
                                      results_checked, out_char_code, rx_want.ch));
          if (out_last !== rx_want.last)
            report_mismatch($sformatf("result %0d: last %b, expected %b",
                                      results_checked, out_last, rx_want.last));
          if (out_modifiers !== rx_want.mods)
            report_mismatch($sformatf("result %0d: modifiers %h, expected %h",
                                      results_checked, out_modifiers, rx_want.mods));
        end
      end
      rx_phase++;
      if (rx_phase % 64 == 0) begin
        case ($urandom_range(0, 3))
          0:       pop_mask = 16'hFFFF;
          1:       pop_mask = 16'($urandom);
          2:       pop_mask = 16'($urandom & $urandom);
          default: pop_mask = 16'($urandom | $urandom);
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!hold_done && beats_seen >= HOLD_AT_BEAT) begin
        // One long hold-off so that both queues fill and push is refused.
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= pop_mask[rx_phase % 16];
      end
    end
  end

  initial begin
    stim_row_t    rows[$];
    line_result_t typed_res;
    logic [7:0]   scan;
    rows.push_back(row(CODE_BACKSPACE, 1, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(CODE_ENTER,     1, 1, KIND_LINE_END,  7'h00, 4'h0));
    rows.push_back(row(8'h9C,          1, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(8'h8E,          1, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(8'h00,          1, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(8'hFF,          1, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(8'h3A,          1, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(8'h80,          1, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(8'h1E,          1, 1, KIND_ECHO_CHAR, 7'h61, 4'h0));
    rows.push_back(row(8'h9E,          1, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(8'h2A,          1, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(8'h1E,          1, 1, KIND_ECHO_CHAR, 7'h41, 4'h1));
    rows.push_back(row(8'h0B,          0, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(8'hAA,          1, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(8'h36,          0, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(8'h35,          0, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(8'hB6,          0, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(8'h1D,          0, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(8'h38,          0, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(8'h39,          0, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(8'h01,          0, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(8'h37,          0, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(8'h9D,          0, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(8'hB8,          0, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(CODE_BACKSPACE, 0, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));
    rows.push_back(row(CODE_ENTER,     0, 0, KIND_ECHO_CHAR, 7'h00, 4'h0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      offer_beat(rows[i].scan);
      if (rows[i].typed) begin
        // The typed-in expectation stands in for the predicted one.
        void'(apply_scancode(rows[i].scan, 1'b0));
        if (rows[i].one_result) begin
          typed_res.kind = rows[i].kind;
          typed_res.ch   = rows[i].ch;
          typed_res.last = 1'b1;
          typed_res.mods = rows[i].mods;
          pending_results.push_back(typed_res);
        end
      end else begin
        void'(apply_scancode(rows[i].scan, 1'b1));
      end
    end

    while (random_beats < RANDOM_BEATS) begin
      if (scan_plan.size() == 0) plan_sequence();
      scan = scan_plan.pop_front();
      offer_beat(scan);
      void'(apply_scancode(scan, 1'b1));
      random_beats++;
    end
    push <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Run covered %0d scancodes and %0d checked results, %0d line ends.",
             beats_seen, results_checked, line_ends);
    $display("Full lines flushed by a following key: %0d; cycles with push refused: %0d.",
             full_drains, full_stalls);
    if (errors == 0) begin
      $display("[scancode_line_editor_top] OK");
    end else begin
      $display("[scancode_line_editor_top] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still awaited.", pending_results.size());
    $display("[scancode_line_editor_top] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sle_pkg.sv
rtl/core/sle_ram.sv
rtl/core/sle_front.sv
rtl/core/sle_cmd_queue.sv
rtl/core/sle_back.sv
rtl/core/scancode_line_editor_top.sv
verif/tb_scancode_line_editor_top.sv
